FILE: rtl/brb_pkg.sv
// Shared types and codes for the byte ring buffer block.
// No dependencies; every other file imports this package.
`default_nettype none

package brb_pkg;

  typedef enum logic [2:0] {
    KIND_PUSH_START = 3'd0,
    KIND_PUSH_DATA  = 3'd1,
    KIND_POP        = 3'd2,
    KIND_READ_AT    = 3'd3,
    KIND_ERASE      = 3'd4,
    KIND_CLEAR      = 3'd5,
    KIND_STATUS     = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_RESP   = 4'b0100,
    ST_STREAM = 4'b1000
  } state_t;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CALC_W = 10;

endpackage

`default_nettype wire

FILE: rtl/brb_store.sv
// Byte-wide buffer memory with one write port and one registered read port.
// Depends on brb_pkg for the byte width.
`default_nettype none

module brb_store
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [BYTE_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/brb_wrap_add.sv
// Shared index adder that wraps its sum at the buffer depth.
// Depends on brb_pkg for the arithmetic width.
`default_nettype none

module brb_wrap_add
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic [AW-1:0]       a,
  input  wire logic [BYTE_W:0]     b,
  output logic      [AW-1:0]       y
);

  logic [CALC_W-1:0] sum;
  logic [CALC_W-1:0] red;

  always_comb begin
    sum = CALC_W'(a) + CALC_W'(b);
    red = (sum >= CALC_W'(DEPTH)) ? sum - CALC_W'(DEPTH) : sum;
    y   = red[AW-1:0];
  end

endmodule

`default_nettype wire

FILE: rtl/byte_ring_buffer_block_ops.sv
// Byte ring buffer with block push, pop, read-at, erase, clear and status.
// A single-result word passes EXEC and RESP into the output register; a pop
// or read-at passes EXEC, then STREAM gives one byte per cycle while the output
// is not stalled, from the one-port read of the buffer memory. The next input
// is taken the cycle after the last result enters the output register.
// Synchronous active-low reset empties the buffer and closes any open push.
`default_nettype none

module byte_ring_buffer_block_ops
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned MAX_BLOCK = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // data_in, length, offset
  input  wire logic [2:0]  in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // data_out, fill_count, contiguous, fits
  output logic             out_tuser,  // status
  output logic             out_tlast
);

  localparam int unsigned AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned BW = $clog2(MAX_BLOCK + 1);

  state_t            state_r, state_nxt;
  logic [2:0]        kind_r;
  logic [BYTE_W-1:0] din_r, len_r, off_r;
  logic [AW-1:0]     head_r, head_nxt, tail_r, tail_nxt;
  logic [BYTE_W-1:0] push_rem_r, push_rem_nxt;
  logic              rej_r, rej_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [BW-1:0]     rd_left_r, rd_left_nxt, emit_left_r, emit_left_nxt;
  logic              rv_r, rv_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_fill_r, out_contig_r;
  logic              out_status_r, out_last_r, out_fits_r;

  logic [AW-1:0]     add_a, add_y;
  logic [BYTE_W:0]   add_b;
  logic              wr_en, rd_en;
  logic [BYTE_W-1:0] rd_data;

  logic [CALC_W-1:0] cnt, free_sp, need;
  logic [CALC_W-1:0] post_fill, post_contig;
  logic              post_fits;
  logic              issue, move, load, load_last;
  logic [BYTE_W-1:0] load_data;

  brb_wrap_add #(.DEPTH(DEPTH), .AW(AW)) u_add (
    .a (add_a),
    .b (add_b),
    .y (add_y)
  );

  brb_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head_r),
    .wr_data (din_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  always_comb begin
    cnt = (head_r >= tail_r) ? CALC_W'(head_r) - CALC_W'(tail_r)
                             : CALC_W'(head_r) + CALC_W'(DEPTH) - CALC_W'(tail_r);
    free_sp     = CALC_W'(DEPTH - 1) - cnt;
    need        = (kind_r == KIND_POP) ? CALC_W'(len_r)
                                       : CALC_W'(len_r) + CALC_W'(off_r);
    post_fill   = cnt;
    post_contig = (head_r >= tail_r) ? cnt : CALC_W'(DEPTH) - CALC_W'(tail_r);
    post_fits   = CALC_W'(len_r) <= free_sp;
  end

  always_comb begin
    if (state_r == ST_STREAM) begin
      add_a = rd_addr_r;
      add_b = (BYTE_W+1)'(1);
    end else if (kind_r == KIND_PUSH_DATA) begin
      add_a = head_r;
      add_b = (BYTE_W+1)'(1);
    end else if (kind_r == KIND_READ_AT) begin
      add_a = tail_r;
      add_b = (BYTE_W+1)'(off_r);
    end else begin
      add_a = tail_r;
      add_b = (BYTE_W+1)'(len_r);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign move      = (state_r == ST_STREAM) && rv_r && (!out_valid_r || out_tready);
  assign issue     = (state_r == ST_STREAM) && (rd_left_r != '0) && (!rv_r || move);
  assign rd_en     = issue;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    push_rem_nxt  = push_rem_r;
    rej_nxt       = rej_r;
    rd_addr_nxt   = rd_addr_r;
    rd_left_nxt   = rd_left_r;
    emit_left_nxt = emit_left_r;
    rv_nxt        = rv_r;
    wr_en         = 1'b0;
    load          = 1'b0;
    load_last     = 1'b1;
    load_data     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rej_nxt   = 1'b0;
        state_nxt = ST_RESP;
        unique case (kind_r)
          KIND_PUSH_START: begin
            if (CALC_W'(len_r) > free_sp) begin
              rej_nxt = 1'b1;
            end else begin
              push_rem_nxt = len_r;
            end
          end
          KIND_PUSH_DATA: begin
            if (push_rem_r == '0) begin
              rej_nxt = 1'b1;
            end else begin
              wr_en        = 1'b1;
              head_nxt     = add_y;
              push_rem_nxt = push_rem_r - 1'b1;
            end
          end
          KIND_POP, KIND_READ_AT: begin
            if (len_r > BYTE_W'(MAX_BLOCK) || need > cnt) begin
              rej_nxt = 1'b1;
            end else if (len_r != '0) begin
              state_nxt     = ST_STREAM;
              rd_left_nxt   = len_r[BW-1:0];
              emit_left_nxt = len_r[BW-1:0];
              rv_nxt        = 1'b0;
              if (kind_r == KIND_POP) begin
                rd_addr_nxt = tail_r;
                tail_nxt    = add_y;
              end else begin
                rd_addr_nxt = add_y;
              end
            end
          end
          KIND_ERASE: begin
            if (CALC_W'(len_r) > cnt) begin
              rej_nxt = 1'b1;
            end else begin
              tail_nxt = add_y;
            end
          end
          KIND_CLEAR: begin
            head_nxt     = '0;
            tail_nxt     = '0;
            push_rem_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_STREAM: begin
        if (issue) begin
          rd_addr_nxt = add_y;
          rd_left_nxt = rd_left_r - 1'b1;
        end
        if (issue) begin
          rv_nxt = 1'b1;
        end else if (move) begin
          rv_nxt = 1'b0;
        end
        if (move) begin
          load          = 1'b1;
          load_data     = rd_data;
          load_last     = (emit_left_r == BW'(1));
          emit_left_nxt = emit_left_r - 1'b1;
          if (emit_left_r == BW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      push_rem_r  <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      push_rem_r  <= push_rem_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser;
      din_r  <= in_tdata[7:0];
      len_r  <= in_tdata[15:8];
      off_r  <= in_tdata[23:16];
    end
    rej_r       <= rej_nxt;
    rd_addr_r   <= rd_addr_nxt;
    rd_left_r   <= rd_left_nxt;
    emit_left_r <= emit_left_nxt;
    if (load) begin
      out_data_r   <= load_data;
      out_status_r <= (state_r == ST_RESP) ? rej_r : 1'b0;
      out_last_r   <= load_last;
      out_fill_r   <= post_fill[BYTE_W-1:0];
      out_contig_r <= post_contig[BYTE_W-1:0];
      out_fits_r   <= post_fits;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_fits_r, out_contig_r, out_fill_r, out_data_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
